// File: rtl/lcdw_pkg.sv
// Package for the character-LCD expander writer: command codes, register
// indexes, the job descriptor passed from front to back and display tables.
// No dependencies.
`timescale 1ns / 1ps

package lcdw_pkg;

   localparam int MAX_COLUMNS = 40;
   localparam int MAX_ROWS    = 4;

   // Input command codes
   localparam logic [2:0] CMD_CHAR  = 3'd0;
   localparam logic [2:0] CMD_CLEAR = 3'd1;
   localparam logic [2:0] CMD_HOME  = 3'd2;
   localparam logic [2:0] CMD_SETPOS = 3'd3;
   localparam logic [2:0] CMD_INIT  = 3'd4;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_COLUMNS   = 2'd0;
   localparam logic [1:0] REG_ROWS      = 2'd1;
   localparam logic [1:0] REG_BACKLIGHT = 2'd2;

   localparam logic [5:0] RESET_COLUMNS = 6'd16;
   localparam logic [2:0] RESET_ROWS    = 3'd2;

   localparam logic [7:0] DDRAM_SET = 8'h80;
   localparam logic [7:0] INIT_RAW  = 8'h08;

   // Index of the last expander byte per job kind
   localparam logic [5:0] ONE_LAST  = 6'd3;
   localparam logic [5:0] TWO_LAST  = 6'd7;
   localparam logic [5:0] INIT_LAST = 6'd32;

   localparam int JOB_DEPTH = 2;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

   typedef struct packed {
      logic [5:0] column_count;
      logic [2:0] row_count;
      logic       backlight_on;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_ONE,   // one display byte
      JOB_TWO,   // character followed by an address command
      JOB_INIT   // power-up sequence
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte0;
      logic         rs0;
      logic [7:0]   byte1;
      logic         backlight;
   } job_type;

   function automatic logic [7:0] row_base(input logic [1:0] r);
      logic [7:0] b;
      case (r)
         2'd0: b = 8'h00;
         2'd1: b = 8'h40;
         2'd2: b = 8'h14;
         2'd3: b = 8'h54;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] ddram_cmd(input logic [1:0] r, input logic [5:0] c);
      return DDRAM_SET | (row_base(r) + {2'b00, c});
   endfunction

   // Nibbles of the power-up sequence after the leading raw byte:
   // 3,3,3,2 then commands 0x28, 0x08, 0x01, 0x06, 0x0C and 0x80.
   function automatic logic [3:0] init_nibble(input logic [3:0] k);
      logic [3:0] n;
      case (k)
         4'd0:  n = 4'h3;
         4'd1:  n = 4'h3;
         4'd2:  n = 4'h3;
         4'd3:  n = 4'h2;
         4'd4:  n = 4'h2;
         4'd5:  n = 4'h8;
         4'd6:  n = 4'h0;
         4'd7:  n = 4'h8;
         4'd8:  n = 4'h0;
         4'd9:  n = 4'h1;
         4'd10: n = 4'h0;
         4'd11: n = 4'h6;
         4'd12: n = 4'h0;
         4'd13: n = 4'hC;
         4'd14: n = 4'h8;
         4'd15: n = 4'h0;
         default: n = 4'h0;
      endcase
      return n;
   endfunction

endpackage

// File: rtl/char_lcd_expander_writer_top.sv
// Top level of the character-LCD expander writer: configuration registers,
// front part, job queue and back part. Depends on lcdw_pkg, lcdw_front,
// lcdw_job_fifo and lcdw_back.
//
//   Channel   Direction  Handshake               Payload
//   req_*     in         req_tvalid/req_tready   tuser: cmd; tdata: char_code, row, col
//   rsp_*     out        rsp_tvalid/rsp_tready   tdata: expander_byte; tlast: last
//   csr_*     in         APB write/read          column_count, row_count, backlight_on
//
// The back part emits the expander bytes of each item: 4 for a plain
// character, command or address move, 8 for a character that wraps, 33 for
// the power-up sequence, and none for an unknown command. The front part
// accepts an item whenever the two-entry job queue has room. Reset clears the
// cursor, the queue and the output stage and loads the register defaults. A
// stalled output holds its byte; the front keeps accepting until the queue is
// full.
`timescale 1ns / 1ps

module char_lcd_expander_writer_top
   import lcdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] char_code, [23:8] row, [39:24] col
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] expander_byte
   output logic        rsp_tlast,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg_ff;
   logic    csr_write;
   logic    set_backlight;
   logic    front_job_valid;
   job_type front_job;
   logic    fifo_not_full;
   logic    fifo_not_empty;
   job_type head_job;
   logic    job_pop;

   // The port never waits; a write lands in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count <= RESET_COLUMNS;
         cfg_ff.row_count    <= RESET_ROWS;
         cfg_ff.backlight_on <= 1'b1;
      end else begin
         if (csr_write) begin
            case (csr_paddr[3:2])
               REG_COLUMNS:   cfg_ff.column_count <= csr_pwdata[5:0];
               REG_ROWS:      cfg_ff.row_count    <= csr_pwdata[2:0];
               REG_BACKLIGHT: cfg_ff.backlight_on <= csr_pwdata[0];
               default:       cfg_ff.column_count <= cfg_ff.column_count;
            endcase
         end
         // The power-up sequence turns the backlight on for later items, until a register write turns it off.
         if (set_backlight) cfg_ff.backlight_on <= 1'b1;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_COLUMNS:   csr_prdata = {26'd0, cfg_ff.column_count};
         REG_ROWS:      csr_prdata = {29'd0, cfg_ff.row_count};
         REG_BACKLIGHT: csr_prdata = {31'd0, cfg_ff.backlight_on};
         default:       csr_prdata = 32'd0;
      endcase
   end

   lcdw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_tvalid),
      .req_cmd       (req_tuser),
      .req_char      (req_tdata[7:0]),
      .req_row       (req_tdata[23:8]),
      .req_col       (req_tdata[39:24]),
      .job_ready     (fifo_not_full),
      .req_ready     (req_tready),
      .job_valid     (front_job_valid),
      .job           (front_job),
      .set_backlight (set_backlight)
   );

   lcdw_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_job_valid),
      .push_job  (front_job),
      .not_full  (fifo_not_full),
      .pop       (job_pop),
      .not_empty (fifo_not_empty),
      .head_job  (head_job)
   );

   lcdw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (fifo_not_empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast),
      .rsp_ready (rsp_tready)
   );

endmodule

// File: rtl/lcdw_front.sv
// Front part: accepts requests, tracks the cursor and turns each request
// into a job descriptor. Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_front
   import lcdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_char,
   input  logic [15:0] req_row,
   input  logic [15:0] req_col,
   input  logic        job_ready,
   output logic        req_ready,
   output logic        job_valid,
   output job_type     job,
   output logic        set_backlight
);

   logic [1:0] cursor_row_ff, cursor_row_in;
   logic [5:0] cursor_col_ff, cursor_col_in;
   logic [5:0] cols_eff;
   logic [2:0] rows_eff;
   logic [2:0] next_row_wide;
   logic [1:0] next_row;
   logic [6:0] next_col;
   logic [1:0] clamp_row;
   logic [5:0] clamp_col;
   logic       accept;

   assign req_ready = job_ready;
   assign accept    = req_valid && job_ready;

   always_comb begin
      if (cfg.column_count == 6'd0) cols_eff = 6'd1;
      else if (cfg.column_count > 6'(MAX_COLUMNS)) cols_eff = 6'(MAX_COLUMNS);
      else cols_eff = cfg.column_count;
      if (cfg.row_count == 3'd0) rows_eff = 3'd1;
      else if (cfg.row_count > 3'(MAX_ROWS)) rows_eff = 3'(MAX_ROWS);
      else rows_eff = cfg.row_count;
   end

   always_comb begin
      next_row_wide = {1'b0, cursor_row_ff} + 3'd1;
      next_row = (next_row_wide >= rows_eff) ? 2'd0 : next_row_wide[1:0];
      next_col = {1'b0, cursor_col_ff} + 7'd1;
      clamp_row = (req_row >= {13'd0, rows_eff}) ? 2'(rows_eff - 3'd1) : req_row[1:0];
      clamp_col = (req_col >= {10'd0, cols_eff}) ? (cols_eff - 6'd1) : req_col[5:0];
   end

   always_comb begin
      job.kind      = JOB_ONE;
      job.byte0     = 8'h00;
      job.rs0       = 1'b0;
      job.byte1     = 8'h00;
      job.backlight = cfg.backlight_on;
      job_valid     = 1'b0;
      set_backlight = 1'b0;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      case (req_cmd)
         CMD_CHAR: begin
            job_valid = accept;
            if (req_char == CHAR_NEWLINE) begin
               job.byte0 = ddram_cmd(next_row, 6'd0);
               cursor_row_in = next_row;
               cursor_col_in = 6'd0;
            end else begin
               job.byte0 = req_char;
               job.rs0   = 1'b1;
               if (next_col >= {1'b0, cols_eff}) begin
                  job.kind  = JOB_TWO;
                  job.byte1 = ddram_cmd(next_row, 6'd0);
                  cursor_row_in = next_row;
                  cursor_col_in = 6'd0;
               end else begin
                  cursor_col_in = next_col[5:0];
               end
            end
         end
         CMD_CLEAR, CMD_HOME: begin
            job_valid = accept;
            job.byte0 = {5'd0, req_cmd};
            cursor_row_in = 2'd0;
            cursor_col_in = 6'd0;
         end
         CMD_SETPOS: begin
            job_valid = accept;
            job.byte0 = ddram_cmd(clamp_row, clamp_col);
            cursor_row_in = clamp_row;
            cursor_col_in = clamp_col;
         end
         CMD_INIT: begin
            job_valid     = accept;
            job.kind      = JOB_INIT;
            job.backlight = 1'b1;
            set_backlight = accept;
            cursor_row_in = 2'd0;
            cursor_col_in = 6'd0;
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff <= 2'd0;
         cursor_col_ff <= 6'd0;
      end else if (accept) begin
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
      end
   end

endmodule

// File: rtl/lcdw_job_fifo.sv
// Short job queue between the front and the back part.
// Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_job_fifo
   import lcdw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head_job
);

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [JOB_PTR_W:0]     count_ff, count_in;

   assign not_full  = (count_ff != (JOB_PTR_W + 1)'(JOB_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/lcdw_back.sv
// Back part: expands the queue head job into expander bytes, one per cycle
// unless stalled, into a registered output stage. Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_back
   import lcdw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   output logic       rsp_valid,
   output logic [7:0] rsp_byte,
   output logic       rsp_last,
   input  logic       rsp_ready
);

   logic [5:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       advance;
   logic       produce;
   logic [5:0] init_k;
   logic [7:0] sel_byte;
   logic [3:0] nib;
   logic       rs;

   assign advance   = !valid_ff || rsp_ready;
   assign produce   = advance && job_valid;
   assign job_pop   = produce && last_in;
   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;

   always_comb begin
      init_k   = idx_ff - 6'd1;
      sel_byte = idx_ff[2] ? job.byte1 : job.byte0;
      rs       = idx_ff[2] ? 1'b0 : job.rs0;
      nib      = idx_ff[1] ? sel_byte[3:0] : sel_byte[7:4];
      byte_in  = {nib, job.backlight, !idx_ff[0], 1'b0, rs};
      last_in  = 1'b0;
      case (job.kind)
         JOB_ONE: last_in = (idx_ff == ONE_LAST);
         JOB_TWO: last_in = (idx_ff == TWO_LAST);
         JOB_INIT: begin
            last_in = (idx_ff == INIT_LAST);
            if (idx_ff == 6'd0) byte_in = INIT_RAW;
            else byte_in = {init_nibble(init_k[4:1]), 1'b1, !init_k[0], 1'b0, 1'b0};
         end
         default: last_in = 1'b1;
      endcase
      idx_in = last_in ? 6'd0 : idx_ff + 6'd1;
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 6'd0;
      end else begin
         if (advance) valid_ff <= job_valid;
         if (produce) idx_ff <= idx_in;
      end
   end

endmodule

// File: rtl/lcdw_checker.sv
// Port-level checks for the character-LCD expander writer, bound to the
// top level. Depends on char_lcd_expander_writer_top.
`timescale 1ns / 1ps

module lcdw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result holds its byte and its end mark.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The display is only ever written, so RW stays low.
   a_rw_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[1])
      else $error("RW bit set in expander byte");

   // Every item ends on a byte with the enable strobe released.
   a_last_en_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[2])
      else $error("last byte has EN set");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind char_lcd_expander_writer_top lcdw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
